// ===== rtl/fph_pkg.sv =====
package fph_pkg;

	localparam int FLOWS     = 1024;
	localparam int FLOW_W    = (FLOWS > 1) ? $clog2(FLOWS) : 1;
	localparam int BINS      = 8;
	localparam int BIN_W     = 3;
	localparam int TIME_BITS = 48;
	localparam int CNT_W     = 32;
	localparam int REC_W     = 5;   // 32 counters per flow record
	localparam int LEN_W     = 16;

	localparam logic MODE_UPDATE  = 1'b0;
	localparam logic MODE_READOUT = 1'b1;

	localparam logic KIND_LENGTH = 1'b0;
	localparam logic KIND_GAP    = 1'b1;

	// log2 band: 0..15 -> 0, 16..31 -> 1 ... 512..1023 -> 6, >= 1024 -> 7
	function automatic logic [BIN_W-1:0] bin_of(input logic [CNT_W-1:0] value);
		logic [BIN_W-1:0] b;
		b = '0;
		if (value[CNT_W-1:10] != '0) b = 3'd7;
		else if (value[9]) b = 3'd6;
		else if (value[8]) b = 3'd5;
		else if (value[7]) b = 3'd4;
		else if (value[6]) b = 3'd3;
		else if (value[5]) b = 3'd2;
		else if (value[4]) b = 3'd1;
		return b;
	endfunction

endpackage

// ===== rtl/flow_packet_histogram.sv =====
// Update: accepted, then read, read, write length bin, write gap bin; input
// stalls until the sequence is back in idle.
// A new_flow packet first clears its record of 32 counters.
// Read-out: 32 results, each read issued once the previous one is captured;
// input stalls until the last result is taken.
// Reset clears control state and count_empty; RAM contents are undefined.
module flow_packet_histogram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [9:0]                    flow_id,
	input  logic                          new_flow,
	input  logic                          from_source,
	input  logic [15:0]                   payload_length,
	input  logic [47:0]                   timestamp_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          histogram_kind,
	output logic                          direction,
	output logic [2:0]                    bin,
	output logic [31:0]                   count,
	output logic                          last
);
	import fph_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLR, ST_RD1, ST_RD2, ST_WR1, ST_WR2, ST_RO
	} state_t;

	localparam int CADDR_W = FLOW_W + REC_W;
	localparam int TADDR_W = FLOW_W + 1;

	state_t                 state_q;
	logic                   count_empty_q;
	logic [FLOW_W-1:0]      flow_q;
	logic                   dir_q;
	logic [LEN_W-1:0]       len_q;
	logic [TIME_BITS-1:0]   ts_q;
	logic [REC_W:0]         ro_cnt_q;     // read requests issued
	logic                   ro_rdv_q;     // read data valid this cycle
	logic [REC_W-1:0]       ro_idx_q;     // index of data on read port

	// output register
	logic                   ov_q;
	logic [REC_W-1:0]       oidx_q;
	logic [CNT_W-1:0]       ocnt_q;

	// memories
	logic [CNT_W-1:0]       cmem [FLOWS*32];
	logic [TIME_BITS-1:0]   tmem [FLOWS*2];
	logic [CADDR_W-1:0]     c_ra, c_wa, c_ra2;
	logic [CNT_W-1:0]       c_rd, c_rd2, c_wd;
	logic                   c_we;
	logic [TADDR_W-1:0]     t_a;
	logic [TIME_BITS-1:0]   t_rd, t_wd;
	logic                   t_we;

	// record clear pass
	logic                   clr_start, clr_done;
	logic [REC_W-1:0]       clr_idx;

	// bin selection for the current packet
	logic [TIME_BITS-1:0]   prev;
	logic [CNT_W-1:0]       gap;
	logic [BIN_W-1:0]       lbin, gbin;
	logic                   skip, gap_ok;

	assign skip   = (len_q == '0) && !count_empty_q;
	assign lbin   = bin_of({{(CNT_W-LEN_W){1'b0}}, len_q});
	assign prev   = t_rd;
	assign gap    = CNT_W'(ts_q - prev);
	assign gbin   = bin_of(gap);
	assign gap_ok = (prev != '0) && (gap != '1);

	// counter address fields: {flow, kind, dir, bin}
	always_comb begin
		c_ra  = {flow_q, KIND_LENGTH, dir_q, lbin};
		c_ra2 = {flow_q, KIND_GAP, dir_q, gbin};
		if (state_q == ST_RO || (state_q == ST_IDLE)) begin
			c_ra = {flow_q, ro_cnt_q[REC_W-1:0]};
		end
	end

	// arrival entry: both directions are zeroed during the clear pass
	assign t_a  = (state_q == ST_CLR) ? {flow_q, clr_idx[0]} : {flow_q, dir_q};
	assign t_wd = (state_q == ST_CLR) ? '0 : ts_q;

	// write data: read data with saturating increment, or zero in the clear pass
	logic [CNT_W-1:0] lcnt, gcnt;
	assign lcnt = c_rd;
	assign gcnt = c_rd2;

	always_comb begin
		c_we = 1'b0;
		c_wa = c_ra;
		c_wd = (lcnt == '1) ? lcnt : lcnt + 1'b1;
		t_we = 1'b0;
		case (state_q)
			ST_CLR: begin
				c_we   = 1'b1;
				c_wa   = {flow_q, clr_idx};
				c_wd   = '0;
				t_we   = (clr_idx[REC_W-1:1] == '0);
			end
			ST_WR1: begin
				c_we   = !skip;
				c_wa   = c_ra;
				c_wd   = (lcnt == '1) ? lcnt : lcnt + 1'b1;
				t_we   = !skip;
			end
			ST_WR2: begin
				c_we   = !skip && gap_ok;
				c_wa   = c_ra2;
				c_wd   = (gcnt == '1) ? gcnt : gcnt + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// counter RAM: two read ports (length and gap bins), one write port
	logic [CNT_W-1:0] c_rd_s1, c_rd2_s1;
	always_ff @(posedge clk) begin
		if (c_we) begin
			cmem[c_wa] <= c_wd;
		end
		c_rd_s1  <= cmem[c_ra];
		c_rd2_s1 <= cmem[c_ra2];
	end
	assign c_rd  = c_rd_s1;
	assign c_rd2 = c_rd2_s1;

	// arrival RAM; zero marks no earlier arrival
	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[t_a] <= t_wd;
		end
		t_rd <= tmem[t_a];
	end

	// new_flow: zero the record before the packet is counted
	assign clr_start = (state_q == ST_IDLE) && in_valid && !in_stall &&
		(mode == MODE_UPDATE) && new_flow;
	fph_rec_clr u_clr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (clr_start),
		.idx    (clr_idx),
		.done   (clr_done)
	);

	assign in_stall  = (state_q != ST_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign histogram_kind = oidx_q[4];
	assign direction = oidx_q[3];
	assign bin       = oidx_q[2:0];
	assign count     = ocnt_q;
	assign last      = (oidx_q == '1);

	// control sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_empty_q <= 1'b0;
			ov_q          <= 1'b0;
			ro_cnt_q      <= '0;
			ro_rdv_q      <= 1'b0;
			ro_idx_q      <= '0;
			oidx_q        <= '0;
			ocnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				count_empty_q <= cfg_wdata;
			end
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						if (mode == MODE_READOUT) begin
							state_q <= ST_RO;
						end else if (new_flow) begin
							state_q <= ST_CLR;
						end else begin
							state_q <= ST_RD1;
						end
						ro_cnt_q <= '0;
						ro_rdv_q <= 1'b0;
					end
				end
				ST_CLR: begin
					if (clr_done) begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_WR1;
				ST_WR1: state_q <= ST_WR2;
				ST_WR2: state_q <= ST_IDLE;
				ST_RO: begin
					// issue reads only when the output slot will be free
					ro_rdv_q <= 1'b0;
					if (!ro_rdv_q && (!ov_q || !out_stall) && ro_cnt_q[REC_W] == 1'b0) begin
						ro_idx_q <= ro_cnt_q[REC_W-1:0];
						ro_cnt_q <= ro_cnt_q + 1'b1;
						ro_rdv_q <= 1'b1;
					end
					if (ro_rdv_q) begin
						ov_q   <= 1'b1;
						oidx_q <= ro_idx_q;
						ocnt_q <= c_rd;
						if (ro_idx_q == '1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !in_stall) begin
			flow_q <= flow_id[FLOW_W-1:0];
			dir_q  <= !from_source;
			len_q  <= payload_length;
			ts_q   <= timestamp_ms[TIME_BITS-1:0];
		end
	end

endmodule

// ===== rtl/fph_rec_clr.sv =====
// Record clear sequencer: walks the 32 counter slots of one flow record,
// one slot per cycle, after a new_flow transaction is taken.
module fph_rec_clr (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic [fph_pkg::REC_W-1:0] idx,
	output logic                      done
);
	import fph_pkg::*;

	logic             busy_q;
	logic [REC_W-1:0] idx_q;

	// slot counter, runs until the last slot of the record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign idx  = idx_q;
	assign done = busy_q && (idx_q == '1);

endmodule

// ===== rtl/fph_checker.sv =====
module fph_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [31:0] count,
	input logic       last
);
	// no new transaction taken while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept during output");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(count) && $stable(last))
		else $error("stalled result changed");
	// once the final result is taken, out_valid drops
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid) else $error("extra result");
endmodule

bind flow_packet_histogram fph_checker u_fph_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .count(count), .last(last)
);
